// ===== rtl/mvkh_pkg.sv =====
// Package for the murmur3 variant key hash block.
// Holds the mix and finalize constants and the sequencer state type.
// No dependencies.
package mvkh_pkg;

  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_M  = 32'd5;
  localparam logic [31:0] MIX_N  = 32'he6546b64;
  localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

  localparam int unsigned ROT_K = 15;
  localparam int unsigned ROT_H = 13;

  localparam logic [2:0] WORD_BYTES = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,   // k = k * C1
    ST_K2,   // k = rotl(k, 15) * C2
    ST_H,    // h = rotl(h ^ k, 13) * 5 + N
    ST_F1,   // first avalanche multiply
    ST_F2    // second avalanche multiply, load output register
  } mvkh_state_e;

endpackage

// ===== rtl/murmur3_variant_key_hash_top.sv =====
// A non-last item is accepted as a full word, then runs the mix states K1, K2 and H. A last
// item runs K1, K2 and H once per tail byte (or once for a full word), then finalize states F1
// and F2 before out_valid_o; all passes run through one shared 32x32 constant multiplier.
// The block takes a new item only while the sequencer is idle; a finished hash waits
// in the output register while the next key starts. Reset (rst_ni low, async) clears
// the sequencer, the key-in-progress flag, the byte total and the output valid.
module murmur3_variant_key_hash_top
  import mvkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] seed_i,
  input  logic [31:0] key_bytes_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  mvkh_state_e state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] total_q, total_d;
  logic [31:0] word_q, word_d;
  logic        inside_q, inside_d;
  logic        last_q, last_d;
  logic [2:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] hash_q, hash_d;

  logic        in_acc;
  logic        out_free;
  logic [2:0]  cnt;
  logic [31:0] mul_a, mul_b, mul_prod;
  logic [31:0] hx, fx, kx, hk;
  logic [1:0]  idx_nx;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // count saturates at four; a non-last item always counts as a full word
  assign cnt = (!last_i || byte_count_i > WORD_BYTES) ? WORD_BYTES : byte_count_i;

  assign hk     = h_q ^ k_q;
  assign hx     = h_q ^ total_q;
  assign fx     = hx ^ (hx >> 16);
  assign kx     = k_q ^ (k_q >> 13);
  assign idx_nx = idx_q + 2'd1;

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = k_q;
    mul_b = MIX_C1;
    case (state_q)
      ST_K1: begin
        mul_a = k_q;
        mul_b = MIX_C1;
      end
      ST_K2: begin
        mul_a = (k_q << ROT_K) | (k_q >> (32 - ROT_K));
        mul_b = MIX_C2;
      end
      ST_H: begin
        mul_a = (hk << ROT_H) | (hk >> (32 - ROT_H));
        mul_b = MIX_M;
      end
      ST_F1: begin
        mul_a = fx;
        mul_b = FIN_C1;
      end
      ST_F2: begin
        mul_a = kx;
        mul_b = FIN_C2;
      end
      default: begin
        mul_a = k_q;
        mul_b = MIX_C1;
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    k_d         = k_q;
    total_d     = total_q;
    word_d      = word_q;
    inside_d    = inside_q;
    last_d      = last_q;
    left_d      = left_q;
    idx_d       = idx_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          h_d     = inside_q ? h_q : seed_i;
          total_d = (inside_q ? total_q : 32'd0) + {29'd0, cnt};
          word_d  = key_bytes_i;
          last_d  = last_i;
          idx_d   = 2'd0;
          if (cnt == WORD_BYTES) begin
            k_d     = key_bytes_i;
            left_d  = 3'd1;
            state_d = ST_K1;
          end else if (cnt == 3'd0) begin
            left_d  = 3'd0;
            state_d = ST_F1;
          end else begin
            k_d     = {24'd0, key_bytes_i[7:0]};
            left_d  = cnt;
            state_d = ST_K1;
          end
        end
      end
      ST_K1: begin
        k_d     = mul_prod;
        state_d = ST_K2;
      end
      ST_K2: begin
        k_d     = mul_prod;
        state_d = ST_H;
      end
      ST_H: begin
        h_d    = mul_prod + MIX_N;
        left_d = left_q - 3'd1;
        if (left_q != 3'd1) begin
          // tail variant: k carries over, next byte folded in
          idx_d   = idx_nx;
          k_d     = k_q ^ {24'd0, word_q[{idx_nx, 3'b000} +: 8]};
          state_d = ST_K1;
        end else if (last_q) begin
          state_d = ST_F1;
        end else begin
          inside_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_F1: begin
        k_d      = mul_prod;
        h_d      = 32'd0;
        total_d  = 32'd0;
        inside_d = 1'b0;
        state_d  = ST_F2;
      end
      ST_F2: begin
        // holds here until the output register is free
        if (out_free) begin
          hash_d      = mul_prod ^ (mul_prod >> 16);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= 32'd0;
      total_q     <= 32'd0;
      inside_q    <= 1'b0;
      left_q      <= 3'd0;
      idx_q       <= 2'd0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      total_q     <= total_d;
      inside_q    <= inside_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    word_q <= word_d;
    hash_q <= hash_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

`ifndef SYNTHESIS
  a_full_word_starts_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_i |=> state_q == ST_K1 && left_q == 3'd1)
    else $error("non-last item did not start a single block mix");

  a_empty_last_finalizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_i && byte_count_i == 3'd0 |=> state_q == ST_F1)
    else $error("empty last item did not go straight to finalize");

  a_mix_has_pass_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K1 || state_q == ST_K2 || state_q == ST_H) |-> left_q != 3'd0)
    else $error("mix pass running with no bytes left");

  a_result_from_finalize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_F2))
    else $error("result appeared without finalize");

  a_finalize_clears_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_F1 |=> !inside_q && total_q == 32'd0)
    else $error("key state not cleared after finalize");
`endif

endmodule
